FILE: hdl/sine_voice_mixer_assert.svh
// assertion macros used by the checker file
`ifndef SINE_VOICE_MIXER_ASSERT_SVH
`define SINE_VOICE_MIXER_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define SVM_ASSERT_NOW(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |-> (cond)) \
		else $error("svm check failed");

// condition holds in the cycle after the trigger
`define SVM_ASSERT_NEXT(label, trig, cond) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (trig) |=> (cond)) \
		else $error("svm check failed");

`endif

FILE: hdl/svm_pkg.sv
// shared constants and widths of the sine voice mixer
package svm_pkg;
	localparam logic [1:0] OP_TICK = 2'd0;
	localparam logic [1:0] OP_SET  = 2'd1;
	localparam logic [1:0] OP_STOP = 2'd2;
	localparam logic [1:0] OP_BEEP = 2'd3;

	localparam logic [1:0] CFG_MASTER_GAIN = 2'd0;
	localparam logic [1:0] CFG_SMOOTHING   = 2'd1;
	localparam logic [1:0] CFG_THRESHOLD   = 2'd2;

	localparam int MUL_A_W = 32;
	localparam int MUL_B_W = 17;
	localparam int MUL_P_W = MUL_A_W + MUL_B_W;

	localparam logic [16:0] MASTER_RESET = 17'd39322;
	localparam logic [16:0] MASTER_MAX   = 17'd65536;
	localparam logic [15:0] SMOOTH_RESET = 16'd131;
	localparam logic [15:0] THRESH_RESET = 16'd66;

	// polynomial quarter-wave constants
	localparam logic [16:0] QS_C1 = 17'd102944;
	localparam logic [16:0] QS_C2 = 17'd42334;
	localparam logic [16:0] QS_C3 = 17'd4926;
	localparam logic [16:0] ONE_Q16 = 17'd65536;
endpackage

FILE: hdl/svm_ifs.sv
// item channels and the configuration write channel
interface svm_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  op;
	logic [7:0]  tone_key;
	logic [30:0] phase_step;
	logic [15:0] volume;
	logic signed [15:0] pan;
	logic [23:0] duration_samples;
	modport source (output valid, op, tone_key, phase_step, volume, pan, duration_samples,
		input ready);
	modport sink (input valid, op, tone_key, phase_step, volume, pan, duration_samples,
		output ready);
endinterface

interface svm_rsp_if;
	logic        valid;
	logic        ready;
	logic        frame_valid;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	logic        dropped;
	modport source (output valid, frame_valid, left_sample, right_sample, dropped,
		input ready);
	modport sink (input valid, frame_valid, left_sample, right_sample, dropped,
		output ready);
endinterface

interface svm_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [16:0] data;
	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

FILE: hdl/svm_mul.sv
// shared unsigned multiplier with registered product
module svm_mul (
	input  logic                        clk,
	input  logic [svm_pkg::MUL_A_W-1:0] a,
	input  logic [svm_pkg::MUL_B_W-1:0] b,
	output logic [svm_pkg::MUL_P_W-1:0] p
);
	always_ff @(posedge clk) begin
		p <= svm_pkg::MUL_P_W'(a) * svm_pkg::MUL_P_W'(b);
	end
endmodule

FILE: hdl/sine_voice_mixer.sv
// top level: voice table, sequencer and mix accumulators of the sine voice mixer
//
//  channel | dir | carries
//  req     | in  | op, tone_key, phase_step, volume, pan, duration_samples
//  rsp     | out | frame_valid, left_sample, right_sample, dropped
//  cfg     | in  | index, data (master gain, smoothing, silence threshold)
//
// a tick walks the voices one by one: a free voice is passed over, a sounding
// voice goes through timing, glide, four multiplies of the sine polynomial and
// four mix multiplies, all on the one shared multiplier; a set or beep computes
// two pan gains with the polynomial, a stop or a dropped item goes to the result
// req is ready only in idle, so no item is taken before the last is done; a result
// waits in the rsp register until taken and the next result is held back behind it
// reset clears the voice in-use flags and loads the register defaults
module sine_voice_mixer #(
	parameter int VOICES          = 16,
	parameter int SINE_TABLE_BITS = 10,
	parameter int FADE_SAMPLES    = 240
) (
	input  logic     clk,
	input  logic     arst_n,
	svm_req_if.sink  req,
	svm_rsp_if.source rsp,
	svm_cfg_if.sink  cfg
);
	localparam int VW       = (VOICES > 1) ? $clog2(VOICES) : 1;
	localparam int ACC_W    = 33 + $clog2(VOICES);
	localparam int SUB_BITS = SINE_TABLE_BITS - 2;
	localparam logic [VW-1:0] LAST_V = VW'(VOICES - 1);
	localparam logic [23:0]   FADE   = 24'(FADE_SAMPLES);

	typedef enum logic [3:0] {
		S_IDLE, S_VOICE, S_GLIDE, S_GLIDE2, S_QXX, S_QT, S_QMID, S_QR, S_QDONE,
		S_M1, S_M2, S_M3, S_M4, S_OUT, S_FIN
	} state_t;

	typedef enum logic [1:0] {RET_SINE, RET_GAIN_R, RET_GAIN_L} ret_t;

	state_t state_q;
	ret_t   ret_q;

	// configuration
	logic [16:0] master_q;
	logic [15:0] coeff_q;
	logic [15:0] thresh_q;

	// voice table
	logic [VOICES-1:0] used_q;
	logic        keyed_q  [VOICES];
	logic [7:0]  key_q    [VOICES];
	logic [31:0] phase_q  [VOICES];
	logic [31:0] step_q   [VOICES];
	logic [15:0] level_q  [VOICES];
	logic [15:0] target_q [VOICES];
	logic [15:0] gl_q     [VOICES];
	logic [15:0] gr_q     [VOICES];
	logic        timed_q  [VOICES];
	logic [23:0] sl_q     [VOICES];

	// working registers
	logic [VW-1:0] v_q;
	logic [VW-1:0] sel_q;
	logic [16:0]   qx_q;
	logic [16:0]   x2_q;
	logic [16:0]   u_q;
	logic [15:0]   tg_q;
	logic [15:0]   gtmp_q;
	logic [31:0]   m_q;
	logic          sneg_q;
	logic signed [ACC_W-1:0] accl_q, accr_q;
	logic          res_frame_q, res_drop_q;
	logic [15:0]   res_l_q, res_r_q;

	// result register
	logic          out_valid_q;
	logic          out_frame_q, out_drop_q;
	logic [15:0]   out_l_q, out_r_q;

	// shared multiplier
	logic [svm_pkg::MUL_A_W-1:0] mul_a;
	logic [svm_pkg::MUL_B_W-1:0] mul_b;
	logic [svm_pkg::MUL_P_W-1:0] mul_p;

	svm_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

	logic accept;
	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign rsp.valid        = out_valid_q;
	assign rsp.frame_valid  = out_frame_q;
	assign rsp.left_sample  = out_l_q;
	assign rsp.right_sample = out_r_q;
	assign rsp.dropped      = out_drop_q;

	// key match and lowest free slot, one compare per voice
	logic          match_hit, free_hit;
	logic [VW-1:0] match_idx, free_idx;
	always_comb begin
		match_hit = 1'b0;
		free_hit  = 1'b0;
		match_idx = '0;
		free_idx  = '0;
		for (int i = VOICES - 1; i >= 0; i--) begin
			if (used_q[i] && keyed_q[i] && key_q[i] == req.tone_key) begin
				match_hit = 1'b1;
				match_idx = VW'(i);
			end
			if (!used_q[i]) begin
				free_hit = 1'b1;
				free_idx = VW'(i);
			end
		end
	end

	// pan position as 0..65535
	logic [16:0] u_in;
	assign u_in = {1'b0, req.pan[15] ^ 1'b1, req.pan[14:0]};

	// per-voice timing decisions
	logic [15:0] cur_lv;
	logic [23:0] cur_sl, sl_dec;
	logic        expired, free_it;
	logic [15:0] tg_next;
	assign cur_lv  = level_q[v_q];
	assign cur_sl  = sl_q[v_q];
	assign sl_dec  = cur_sl - 24'd1;
	assign expired = timed_q[v_q] && (cur_sl == '0);
	assign free_it = expired && (cur_lv < thresh_q);
	always_comb begin
		tg_next = target_q[v_q];
		if (timed_q[v_q] && (expired || sl_dec < FADE)) begin
			tg_next = '0;
		end
	end

	// glide
	logic        glide_up;
	logic [15:0] glide_d;
	logic [32:0] glide_sum;
	logic [15:0] glide_s;
	assign glide_up  = tg_q > cur_lv;
	assign glide_d   = glide_up ? tg_q - cur_lv : cur_lv - tg_q;
	assign glide_sum = mul_p[32:0] + 33'd65535;
	assign glide_s   = glide_sum[31:16];

	// sine polynomial argument from the phase
	logic [SINE_TABLE_BITS-1:0] sidx;
	logic [16:0] t_lin, t_arg;
	assign sidx  = phase_q[v_q][31 -: SINE_TABLE_BITS];
	assign t_lin = 17'(sidx[SUB_BITS-1:0]) << (16 - SUB_BITS);
	assign t_arg = sidx[SUB_BITS] ? svm_pkg::ONE_Q16 - t_lin : t_lin;

	// polynomial result and derived values
	logic [16:0] q_r;
	logic [17:0] q_r1;
	logic [14:0] sine_mag;
	logic [15:0] q_gain;
	assign q_r      = mul_p[32:16];
	assign q_r1     = 18'(q_r) + 18'd1;
	assign sine_mag = (q_r1[17:1] > 17'd32767) ? 15'h7fff : q_r1[15:1];
	assign q_gain   = (q_r > 17'd65535) ? 16'hffff : q_r[15:0];

	// operand selection for the shared multiplier
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			S_QXX: begin
				mul_a = 32'(qx_q);
				mul_b = qx_q;
			end
			S_QT: begin
				mul_a = 32'(mul_p[32:16]);
				mul_b = svm_pkg::QS_C3;
			end
			S_QMID: begin
				mul_a = 32'(x2_q);
				mul_b = svm_pkg::QS_C2 - mul_p[32:16];
			end
			S_QR: begin
				mul_a = 32'(qx_q);
				mul_b = svm_pkg::QS_C1 - mul_p[32:16];
			end
			S_GLIDE: begin
				mul_a = 32'(glide_d);
				mul_b = 17'(coeff_q);
			end
			S_QDONE: begin
				mul_a = 32'(sine_mag);
				mul_b = 17'(level_q[v_q]);
			end
			S_M1: begin
				mul_a = mul_p[31:0];
				mul_b = master_q;
			end
			S_M2: begin
				mul_a = mul_p[47:16];
				mul_b = 17'(gl_q[v_q]);
			end
			S_M3: begin
				mul_a = m_q;
				mul_b = 17'(gr_q[v_q]);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// truncate toward zero to q1.15 and saturate
	function automatic logic [15:0] to_q15(input logic signed [ACC_W-1:0] acc);
		logic                neg;
		logic [ACC_W-1:0]    mag;
		logic [ACC_W-17:0]   qm;
		logic [16:0]         qn;
		neg = acc[ACC_W-1];
		mag = neg ? ACC_W'(-acc) : ACC_W'(acc);
		qm  = mag[ACC_W-1:16];
		qn  = 17'd0 - qm[16:0];
		if (!neg) begin
			to_q15 = (qm > (ACC_W-16)'(32767)) ? 16'h7fff : qm[15:0];
		end else begin
			to_q15 = (qm > (ACC_W-16)'(32768)) ? 16'h8000 : qn[15:0];
		end
	endfunction

	logic [31:0] ml;
	assign ml = mul_p[47:16];

	logic last_v;
	assign last_v = (v_q == LAST_V);

	// control state: sequencer, in-use flags, registers, result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			ret_q       <= RET_SINE;
			v_q         <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
			master_q    <= svm_pkg::MASTER_RESET;
			coeff_q     <= svm_pkg::SMOOTH_RESET;
			thresh_q    <= svm_pkg::THRESH_RESET;
		end else begin
			// in the final state the result register is reloaded below
			if (rsp.valid && rsp.ready && state_q != S_FIN) begin
				out_valid_q <= 1'b0;
			end
			if (cfg.valid) begin
				case (cfg.index)
					svm_pkg::CFG_MASTER_GAIN: master_q <= (cfg.data > svm_pkg::MASTER_MAX) ?
						svm_pkg::MASTER_MAX : cfg.data;
					svm_pkg::CFG_SMOOTHING: coeff_q  <= cfg.data[15:0];
					svm_pkg::CFG_THRESHOLD: thresh_q <= cfg.data[15:0];
					default: ;
				endcase
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.op)
							svm_pkg::OP_TICK: begin
								v_q     <= '0;
								state_q <= S_VOICE;
							end
							svm_pkg::OP_SET: begin
								if (match_hit) begin
									ret_q   <= RET_GAIN_R;
									state_q <= S_QXX;
								end else if (free_hit) begin
									used_q[free_idx] <= 1'b1;
									ret_q   <= RET_GAIN_R;
									state_q <= S_QXX;
								end else begin
									state_q <= S_FIN;
								end
							end
							svm_pkg::OP_BEEP: begin
								if (free_hit) begin
									used_q[free_idx] <= 1'b1;
									ret_q   <= RET_GAIN_R;
									state_q <= S_QXX;
								end else begin
									state_q <= S_FIN;
								end
							end
							default: state_q <= S_FIN;
						endcase
					end
				end
				S_VOICE: begin
					if (!used_q[v_q] || free_it) begin
						if (free_it) begin
							used_q[v_q] <= 1'b0;
						end
						if (last_v) begin
							state_q <= S_OUT;
						end else begin
							v_q <= v_q + 1'b1;
						end
					end else begin
						state_q <= S_GLIDE;
					end
				end
				S_GLIDE:  state_q <= S_GLIDE2;
				S_GLIDE2: begin
					ret_q   <= RET_SINE;
					state_q <= S_QXX;
				end
				S_QXX:  state_q <= S_QT;
				S_QT:   state_q <= S_QMID;
				S_QMID: state_q <= S_QR;
				S_QR:   state_q <= S_QDONE;
				S_QDONE: begin
					case (ret_q)
						RET_SINE:   state_q <= S_M1;
						RET_GAIN_R: begin
							ret_q   <= RET_GAIN_L;
							state_q <= S_QXX;
						end
						default: state_q <= S_FIN;
					endcase
				end
				S_M1: state_q <= S_M2;
				S_M2: state_q <= S_M3;
				S_M3: state_q <= S_M4;
				S_M4: begin
					if (last_v) begin
						state_q <= S_OUT;
					end else begin
						v_q     <= v_q + 1'b1;
						state_q <= S_VOICE;
					end
				end
				S_OUT: state_q <= S_FIN;
				S_FIN: begin
					if (!out_valid_q || rsp.ready) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// voice table contents and datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					res_frame_q <= (req.op == svm_pkg::OP_TICK);
					res_drop_q  <= ((req.op == svm_pkg::OP_SET) && !match_hit && !free_hit) ||
						((req.op == svm_pkg::OP_BEEP) && !free_hit);
					res_l_q     <= '0;
					res_r_q     <= '0;
					accl_q      <= '0;
					accr_q      <= '0;
					u_q         <= u_in;
					qx_q        <= u_in;
					case (req.op)
						svm_pkg::OP_SET: begin
							if (match_hit) begin
								sel_q <= match_idx;
								step_q[match_idx]   <= 32'(req.phase_step);
								target_q[match_idx] <= req.volume;
							end else if (free_hit) begin
								sel_q <= free_idx;
								keyed_q[free_idx]  <= 1'b1;
								key_q[free_idx]    <= req.tone_key;
								phase_q[free_idx]  <= '0;
								step_q[free_idx]   <= 32'(req.phase_step);
								level_q[free_idx]  <= '0;
								target_q[free_idx] <= req.volume;
								timed_q[free_idx]  <= 1'b0;
								sl_q[free_idx]     <= '0;
							end
						end
						svm_pkg::OP_STOP: begin
							for (int i = 0; i < VOICES; i++) begin
								if (used_q[i] && keyed_q[i] && key_q[i] == req.tone_key) begin
									target_q[i] <= '0;
									timed_q[i]  <= 1'b1;
									sl_q[i]     <= '0;
								end
							end
						end
						svm_pkg::OP_BEEP: begin
							if (free_hit) begin
								sel_q <= free_idx;
								keyed_q[free_idx]  <= 1'b0;
								key_q[free_idx]    <= '0;
								phase_q[free_idx]  <= '0;
								step_q[free_idx]   <= 32'(req.phase_step);
								level_q[free_idx]  <= '0;
								target_q[free_idx] <= req.volume;
								timed_q[free_idx]  <= 1'b1;
								sl_q[free_idx]     <= req.duration_samples;
							end
						end
						default: ;
					endcase
				end
			end
			S_VOICE: begin
				if (used_q[v_q] && !free_it) begin
					if (timed_q[v_q] && !expired) begin
						sl_q[v_q] <= sl_dec;
					end
					tg_q <= tg_next;
				end
			end
			S_GLIDE2: begin
				level_q[v_q] <= glide_up ? cur_lv + glide_s : cur_lv - glide_s;
				qx_q         <= t_arg;
				sneg_q       <= sidx[SINE_TABLE_BITS-1];
				phase_q[v_q] <= phase_q[v_q] + step_q[v_q];
			end
			S_QT: x2_q <= mul_p[32:16];
			S_QDONE: begin
				case (ret_q)
					RET_GAIN_R: begin
						gtmp_q <= q_gain;
						qx_q   <= svm_pkg::ONE_Q16 - u_q;
					end
					RET_GAIN_L: begin
						gr_q[sel_q] <= gtmp_q;
						gl_q[sel_q] <= q_gain;
					end
					default: ;
				endcase
			end
			S_M2: m_q <= mul_p[47:16];
			S_M3: accl_q <= sneg_q ? accl_q - $signed(ACC_W'(ml)) : accl_q + $signed(ACC_W'(ml));
			S_M4: accr_q <= sneg_q ? accr_q - $signed(ACC_W'(ml)) : accr_q + $signed(ACC_W'(ml));
			S_OUT: begin
				res_l_q <= to_q15(accl_q);
				res_r_q <= to_q15(accr_q);
			end
			S_FIN: begin
				if (!out_valid_q || rsp.ready) begin
					out_frame_q <= res_frame_q;
					out_drop_q  <= res_drop_q;
					out_l_q     <= res_l_q;
					out_r_q     <= res_r_q;
				end
			end
			default: ;
		endcase
	end
endmodule

FILE: hdl/svm_checker.sv
// port-level checks of the sine voice mixer and their binding
`include "sine_voice_mixer_assert.svh"

module svm_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        frame_valid,
	input logic [15:0] left_sample,
	input logic [15:0] right_sample,
	input logic        dropped
);
	// a waiting result stays offered
	`SVM_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
	// non-frame results carry silence
	`SVM_ASSERT_NOW(a_quiet, rsp_valid && !frame_valid, left_sample == 16'd0 && right_sample == 16'd0)
	// a tick never reports a drop
	`SVM_ASSERT_NOW(a_no_drop, rsp_valid && frame_valid, !dropped)
	// an accepted item keeps the block busy next cycle
	`SVM_ASSERT_NEXT(a_busy, req_valid && req_ready, !req_ready)
endmodule

bind sine_voice_mixer svm_checker u_svm_checker (
	.clk(clk),
	.arst_n(arst_n),
	.req_valid(req.valid),
	.req_ready(req.ready),
	.rsp_valid(rsp.valid),
	.rsp_ready(rsp.ready),
	.frame_valid(rsp.frame_valid),
	.left_sample(rsp.left_sample),
	.right_sample(rsp.right_sample),
	.dropped(rsp.dropped)
);
